// ===== rtl/core/ptc_pkg.sv =====
// Shared types, widths and codes of the pulse train capture block.
package ptc_pkg;

   // Interval store.
   localparam int STORE_DEPTH = 2048;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

   // Fixed field widths.
   localparam int TIME_W      = 24;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int CFG_EDGE_W  = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int CMP_W       = (COUNT_W > CFG_EDGE_W) ? COUNT_W : CFG_EDGE_W;

   // Register reset values.
   localparam logic [TIME_W-1:0]     IDLE_TIMEOUT_RESET = TIME_W'(30000);
   localparam logic [TIME_W-1:0]     ABORT_RESET        = TIME_W'(5 * 1000 * 1000);
   localparam logic [CFG_EDGE_W-1:0] MIN_EDGES_RESET    = CFG_EDGE_W'(10);
   localparam logic [CFG_EDGE_W-1:0] MAX_EDGES_RESET    = CFG_EDGE_W'(2000);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START  = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IDLE_TIMEOUT = 2'd0,
      CSR_ABORT        = 2'd1,
      CSR_MIN_EDGES    = 2'd2,
      CSR_MAX_EDGES    = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_CAPT    = 5'b00010,
      PH_DONE    = 5'b00100,
      PH_SHORT   = 5'b01000,
      PH_TIMEOUT = 5'b10000
   } phase_type;

   localparam logic [STATUS_W-1:0] STATUS_IDLE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_CAPT    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SHORT   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 3'd4;

   // Result word less the interval, carried alongside the store read.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  edge_total;
      logic                hit;
      logic                last;
   } rsp_meta_type;

   function automatic logic [STATUS_W-1:0] phase_status(phase_type ph);
      logic [STATUS_W-1:0] code;
      unique case (ph)
         PH_IDLE:    code = STATUS_IDLE;
         PH_CAPT:    code = STATUS_CAPT;
         PH_DONE:    code = STATUS_DONE;
         PH_SHORT:   code = STATUS_SHORT;
         PH_TIMEOUT: code = STATUS_TIMEOUT;
         default:    code = STATUS_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/ptc_if.sv =====
// Request and response channel interfaces of the pulse train capture block.
interface ptc_req_if import ptc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic              rx_level;

   modport source (output valid, output func, output rx_level, input ready);
   modport sink   (input valid, input func, input rx_level, output ready);
endinterface

interface ptc_rsp_if import ptc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  edge_total;
   logic [TIME_W-1:0]   interval_ticks;
   logic                interval_valid;
   logic                last_interval;

   modport source (output valid, output status, output edge_total, output interval_ticks,
                   output interval_valid, output last_interval, input ready);
   modport sink   (input valid, input status, input edge_total, input interval_ticks,
                   input interval_valid, input last_interval, output ready);
endinterface

// ===== rtl/core/ptc_store.sv =====
// Interval store: single write port, registered read port.
module ptc_store import ptc_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [TIME_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_data
);

   logic [TIME_W-1:0] mem [STORE_DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pulse_train_capture.sv =====
// Top level of the pulse train capture block.
//
// Usage:
//  - req_chan carries one word per item: func (start, sample tick, read) and rx_level.
//    A start clears the counters and arms capture; each sample word is one
//    microsecond tick of the receiver; read words drain the captured intervals.
//  - rsp_chan returns exactly one word per request word, in order: status,
//    edge_total and, for a successful read, the interval with its last flag.
//  - csr_we/csr_index/csr_wdata write the idle limit, abort limit and the
//    minimum and maximum edge counts; write them only while the block is idle.
// Timing:
//  - One word accepted per cycle while rsp_chan is not held. Each accepted request
//    passes through the store stage (control update and store access) and then
//    the response register, which the registered store read feeds.
//  - Control state updates in the cycle of acceptance, so samples and reads may
//    follow each other back to back; the store write of an interval lands at
//    that same edge, before any later read can address it.
// Reset: synchronous; registers return to their reset values, capture goes
//   idle, no response is pending. The store contents are left undefined.
// Stall: when rsp_chan is held, the response register keeps its word and one
//   more request may be taken into the store stage; then req_chan.ready drops.
module pulse_train_capture import ptc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ptc_req_if.sink                req_chan,
   ptc_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers
   logic [TIME_W-1:0]     idle_timeout_ff;
   logic [TIME_W-1:0]     abort_ff;
   logic [CFG_EDGE_W-1:0] min_edges_ff;
   logic [CFG_EDGE_W-1:0] max_edges_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
         abort_ff        <= ABORT_RESET;
         min_edges_ff    <= MIN_EDGES_RESET;
         max_edges_ff    <= MAX_EDGES_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_wdata[TIME_W-1:0];
            CSR_ABORT:        abort_ff        <= csr_wdata[TIME_W-1:0];
            CSR_MIN_EDGES:    min_edges_ff    <= csr_wdata[CFG_EDGE_W-1:0];
            CSR_MAX_EDGES:    max_edges_ff    <= csr_wdata[CFG_EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture state
   phase_type          phase_ff,       phase_in;
   logic [TIME_W-1:0]  tick_ff,        tick_in;
   logic               prev_level_ff,  prev_level_in;
   logic [TIME_W-1:0]  last_edge_ff,   last_edge_in;
   logic [COUNT_W-1:0] edge_count_ff,  edge_count_in;
   logic [ADDR_W-1:0]  read_index_ff,  read_index_in;

   // Pipeline: store stage, then response register
   logic               s1_valid_ff,  s1_valid_in;
   rsp_meta_type       s1_meta_ff,   s1_meta_in;
   logic               out_valid_ff, out_valid_in;
   rsp_meta_type       out_meta_ff,  out_meta_in;
   logic [TIME_W-1:0]  out_ival_ff,  out_ival_in;

   logic               accept;
   logic               advance;
   func_type           func;

   // Sample datapath
   logic               is_edge;
   logic [COUNT_W-1:0] count_edge;
   logic [TIME_W-1:0]  edge_time;
   logic [TIME_W-1:0]  gap;
   logic [CMP_W-1:0]   limit;
   logic               at_limit;
   logic               too_short;

   // Read datapath
   logic               rd_ok;
   logic               rd_last;

   // Store ports
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [TIME_W-1:0]  wr_data;
   logic               rd_en;
   logic [TIME_W-1:0]  rd_data;

   assign func    = func_type'(req_chan.func);
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept  = req_chan.valid && req_chan.ready;

   // Edge handling: the count saturates at the store depth.
   assign is_edge    = req_chan.rx_level != prev_level_ff;
   assign count_edge = (edge_count_ff < COUNT_W'(STORE_DEPTH)) ?
                       edge_count_ff + COUNT_W'(1) : edge_count_ff;
   assign edge_time  = is_edge ? tick_ff : last_edge_ff;
   assign gap        = tick_ff - edge_time;

   // Clamp the edge limit into two to the store depth.
   always_comb begin
      limit = CMP_W'(max_edges_ff);
      if (limit < CMP_W'(2)) begin
         limit = CMP_W'(2);
      end else if (limit > CMP_W'(STORE_DEPTH)) begin
         limit = CMP_W'(STORE_DEPTH);
      end
   end

   assign at_limit  = CMP_W'(is_edge ? count_edge : edge_count_ff) >= limit;
   assign too_short = CMP_W'(is_edge ? count_edge : edge_count_ff) < CMP_W'(min_edges_ff);

   // Every edge after the first stores the interval since the previous one.
   assign wr_en   = accept && (func == FUNC_SAMPLE) && (phase_ff == PH_CAPT) && is_edge &&
                    (edge_count_ff != '0);
   assign wr_addr = ADDR_W'(edge_count_ff - COUNT_W'(1));
   assign wr_data = tick_ff - last_edge_ff;

   // Reads drain entries zero to edge count minus two.
   assign rd_ok   = (phase_ff == PH_DONE) && (edge_count_ff >= COUNT_W'(2)) &&
                    (COUNT_W'(read_index_ff) < edge_count_ff - COUNT_W'(1));
   assign rd_last = COUNT_W'(read_index_ff) == edge_count_ff - COUNT_W'(2);
   assign rd_en   = accept && (func == FUNC_READ) && rd_ok;

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      prev_level_in = prev_level_ff;
      last_edge_in  = last_edge_ff;
      edge_count_in = edge_count_ff;
      read_index_in = read_index_ff;
      s1_meta_in    = s1_meta_ff;
      s1_meta_in.hit  = 1'b0;
      s1_meta_in.last = 1'b0;

      if (accept) begin
         unique case (func)
            FUNC_START: begin
               phase_in      = PH_CAPT;
               tick_in       = '0;
               prev_level_in = 1'b0;
               last_edge_in  = '0;
               edge_count_in = '0;
               read_index_in = '0;
            end
            FUNC_SAMPLE: begin
               if (phase_ff == PH_CAPT) begin
                  if (tick_ff != TIME_MAX) begin
                     tick_in = tick_ff + TIME_W'(1);
                  end
                  if (is_edge) begin
                     edge_count_in = count_edge;
                     last_edge_in  = tick_ff;
                     prev_level_in = req_chan.rx_level;
                  end
                  // Abort first, then idle gap or edge limit.
                  if (tick_ff > abort_ff) begin
                     phase_in = PH_TIMEOUT;
                  end else if ((edge_count_in > COUNT_W'(1)) &&
                               ((gap > idle_timeout_ff) || at_limit)) begin
                     phase_in = too_short ? PH_SHORT : PH_DONE;
                  end
               end
            end
            FUNC_READ: begin
               if (rd_ok) begin
                  s1_meta_in.hit  = 1'b1;
                  s1_meta_in.last = rd_last;
                  read_index_in   = read_index_ff + ADDR_W'(1);
               end
            end
            default: ;
         endcase
         s1_meta_in.status     = phase_status(phase_in);
         s1_meta_in.edge_total = edge_count_in;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_meta_in  = out_meta_ff;
      out_ival_in  = out_ival_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         out_meta_in  = s1_meta_ff;
         out_ival_in  = s1_meta_ff.hit ? rd_data : '0;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         prev_level_ff <= 1'b0;
         last_edge_ff  <= '0;
         edge_count_ff <= '0;
         read_index_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         prev_level_ff <= prev_level_in;
         last_edge_ff  <= last_edge_in;
         edge_count_ff <= edge_count_in;
         read_index_ff <= read_index_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
      out_meta_ff <= out_meta_in;
      out_ival_ff <= out_ival_in;
   end

   ptc_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (read_index_ff),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_meta_ff.status;
   assign rsp_chan.edge_total     = out_meta_ff.edge_total;
   assign rsp_chan.interval_ticks = out_ival_ff;
   assign rsp_chan.interval_valid = out_meta_ff.hit;
   assign rsp_chan.last_interval  = out_meta_ff.last;

endmodule

// ===== rtl/core/ptc_checker.sv =====
// Port-level assertions for the pulse train capture block, with its bind.
module ptc_checker import ptc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [COUNT_W-1:0]  rsp_edge_total,
   input logic [TIME_W-1:0]   rsp_interval_ticks,
   input logic                rsp_interval_valid,
   input logic                rsp_last_interval
);

   // No word may be offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word offered straight after reset");

   // A stalled word holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_edge_total) && $stable(rsp_interval_ticks) &&
      $stable(rsp_interval_valid) && $stable(rsp_last_interval))
      else $error("stalled response word changed");

   // An interval is only read out of a finished capture.
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_interval_valid |-> rsp_status == STATUS_DONE &&
      rsp_edge_total >= COUNT_W'(2))
      else $error("interval returned outside a done capture");

   // Without an interval, interval and last flag stay clear.
   a_no_read_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_interval_valid |-> rsp_interval_ticks == '0 && !rsp_last_interval)
      else $error("stray interval data");

   // Once the last interval has gone, a further read word finds nothing.
   a_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_interval_valid && rsp_last_interval ##1
      rsp_valid && rsp_status == STATUS_DONE |-> !rsp_interval_valid)
      else $error("interval returned after the last one");

endmodule

bind pulse_train_capture ptc_checker u_ptc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_edge_total     (rsp_chan.edge_total),
   .rsp_interval_ticks (rsp_chan.interval_ticks),
   .rsp_interval_valid (rsp_chan.interval_valid),
   .rsp_last_interval  (rsp_chan.last_interval)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the pulse train capture block: scoreboard, drivers and run control.
`timescale 1ns / 1ps

module testbench;
   import ptc_pkg::*;

   // Spare function code the block must ignore.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int RANDOM_WORDS   = 600;
   localparam int PHASE_WORDS    = 70;

   // One response word as the block returns it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  edge_total;
      logic [TIME_W-1:0]   interval_ticks;
      logic                interval_valid;
      logic                last_interval;
   } capture_word_type;

   // Shadow of the capture engine plus the queue of words still owed by the block.
   class capture_scoreboard_type;
      logic [TIME_W-1:0]     idle_lim;
      logic [TIME_W-1:0]     abort_lim;
      logic [CFG_EDGE_W-1:0] min_lim;
      logic [CFG_EDGE_W-1:0] max_lim;

      logic [STATUS_W-1:0]   status;
      logic [TIME_W-1:0]     tick_now;
      logic [TIME_W-1:0]     last_edge;
      logic                  level_seen;
      int                    edge_cnt;
      int                    read_pos;
      logic [TIME_W-1:0]     interval_mem [STORE_DEPTH];

      capture_word_type      owed_words [$];
      int                    failures;
      int                    intervals_read;

      function void clear();
         idle_lim       = IDLE_TIMEOUT_RESET;
         abort_lim      = ABORT_RESET;
         min_lim        = MIN_EDGES_RESET;
         max_lim        = MAX_EDGES_RESET;
         status         = STATUS_IDLE;
         tick_now       = '0;
         last_edge      = '0;
         level_seen     = 1'b0;
         edge_cnt       = 0;
         read_pos       = 0;
         failures       = 0;
         intervals_read = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_IDLE_TIMEOUT: idle_lim  = value;
            CSR_ABORT:        abort_lim = value;
            CSR_MIN_EDGES:    min_lim   = value[CFG_EDGE_W-1:0];
            CSR_MAX_EDGES:    max_lim   = value[CFG_EDGE_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_tick(logic lvl);
         logic [TIME_W-1:0] now;
         logic [TIME_W-1:0] span;
         int                lim;
         now = tick_now;
         if (tick_now != TIME_MAX) tick_now++;
         if (lvl != level_seen) begin
            if (edge_cnt >= 1) interval_mem[ADDR_W'(edge_cnt - 1)] = now - last_edge;
            if (edge_cnt < STORE_DEPTH) edge_cnt++;
            last_edge  = now;
            level_seen = lvl;
         end
         lim = int'(max_lim);
         if (lim < 2) lim = 2;
         if (lim > STORE_DEPTH) lim = STORE_DEPTH;
         span = now - last_edge;
         if (now > abort_lim)
            status = STATUS_TIMEOUT;
         else if (edge_cnt > 1 && (span > idle_lim || edge_cnt >= lim))
            status = (edge_cnt < int'(min_lim)) ? STATUS_SHORT : STATUS_DONE;
      endfunction

      function void note_word(logic [FUNC_W-1:0] f, logic lvl);
         capture_word_type w;
         w = '0;
         case (f)
            FUNC_START: begin
               status     = STATUS_CAPT;
               tick_now   = '0;
               last_edge  = '0;
               level_seen = 1'b0;
               edge_cnt   = 0;
               read_pos   = 0;
            end
            FUNC_SAMPLE: begin
               if (status == STATUS_CAPT) take_tick(lvl);
            end
            FUNC_READ: begin
               if (status == STATUS_DONE && edge_cnt >= 2 && read_pos < edge_cnt - 1) begin
                  w.interval_ticks = interval_mem[ADDR_W'(read_pos)];
                  w.interval_valid = 1'b1;
                  w.last_interval  = (read_pos == edge_cnt - 2);
                  read_pos++;
               end
            end
            default: ;
         endcase
         w.status     = status;
         w.edge_total = COUNT_W'(edge_cnt);
         owed_words.push_back(w);
      endfunction

      function void check_word(capture_word_type got);
         capture_word_type want;
         if (owed_words.size() == 0) begin
            $error("response word arrived with nothing outstanding");
            failures++;
            return;
         end
         want = owed_words.pop_front();
         if (want.interval_valid) intervals_read++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.edge_total !== want.edge_total) begin
            $error("edge_total: expected %0d, got %0d", want.edge_total, got.edge_total);
            failures++;
         end
         if (got.interval_ticks !== want.interval_ticks) begin
            $error("interval_ticks: expected %0d, got %0d",
                   want.interval_ticks, got.interval_ticks);
            failures++;
         end
         if (got.interval_valid !== want.interval_valid) begin
            $error("interval_valid: expected %0d, got %0d",
                   want.interval_valid, got.interval_valid);
            failures++;
         end
         if (got.last_interval !== want.last_interval) begin
            $error("last_interval: expected %0d, got %0d",
                   want.last_interval, got.last_interval);
            failures++;
         end
      endfunction

      function int pending();
         return owed_words.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ptc_req_if req_chan ();
   ptc_rsp_if rsp_chan ();

   capture_scoreboard_type sb;

   // Shared run controls: random idling on both sides, and a one-off receiver hold-off.
   bit gaps_on;
   bit holdoff_go;
   int words_sent;
   int n_done;
   int n_short;
   int n_timeout;

   pulse_train_capture i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Note every accepted request word; the prediction is made at the edge it is taken.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_word(req_chan.func, req_chan.rx_level);
   end

   // Check every accepted response word against the oldest outstanding prediction.
   always @(posedge clock) begin
      capture_word_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status         = rsp_chan.status;
         got.edge_total     = rsp_chan.edge_total;
         got.interval_ticks = rsp_chan.interval_ticks;
         got.interval_valid = rsp_chan.interval_valid;
         got.last_interval  = rsp_chan.last_interval;
         sb.check_word(got);
      end
   end

   // Receiver: stall at random while idling is on; on request, hold off for a long
   // stretch so the block fills and pushes back on the request side.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_go) begin
            holdoff_go = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else begin
            rsp_chan.ready <= !(gaps_on && $urandom_range(99) < 17);
         end
      end
   end

   // Offer one word, with an occasional gap first; return at the falling edge after
   // acceptance with valid still high, so the next word can follow back to back.
   task automatic send_word(logic [FUNC_W-1:0] f, logic lvl);
      while (gaps_on && $urandom_range(99) < 17) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.func     <= f;
      req_chan.rx_level <= lvl;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      words_sent++;
   endtask

   // Drop valid, wait for every owed response, then allow the pipeline to empty.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write all four registers back to back; only call with the block idle.
   task automatic program_regs(logic [TIME_W-1:0] idle_v, logic [TIME_W-1:0] abort_v,
                               logic [CFG_EDGE_W-1:0] min_v, logic [CFG_EDGE_W-1:0] max_v);
      csr_we    <= 1'b1;
      csr_index <= CSR_IDLE_TIMEOUT;
      csr_wdata <= idle_v;
      sb.set_reg(CSR_IDLE_TIMEOUT, idle_v);
      @(negedge clock);
      csr_index <= CSR_ABORT;
      csr_wdata <= abort_v;
      sb.set_reg(CSR_ABORT, abort_v);
      @(negedge clock);
      csr_index <= CSR_MIN_EDGES;
      csr_wdata <= CSR_DATA_W'(min_v);
      sb.set_reg(CSR_MIN_EDGES, CSR_DATA_W'(min_v));
      @(negedge clock);
      csr_index <= CSR_MAX_EDGES;
      csr_wdata <= CSR_DATA_W'(max_v);
      sb.set_reg(CSR_MAX_EDGES, CSR_DATA_W'(max_v));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One capture: start, a pulse train of random run lengths until the shadow shows
   // the capture has ended (or the sample budget runs out), then drain the intervals.
   task automatic run_capture(int budget, bit noisy);
      int   max_run;
      int   run;
      int   taken;
      int   reads;
      logic lvl;
      // Keep runs mostly inside the idle limit so trains carry several edges.
      max_run = (sb.idle_lim > 13) ? 16 : int'(sb.idle_lim) + 3;
      send_word(FUNC_START, 1'($urandom_range(1)));
      taken = 0;
      while (sb.status == STATUS_CAPT && taken < budget) begin
         run = $urandom_range(1, max_run);
         // Mostly toggle the level; now and then repeat it so no edge lands.
         lvl = ($urandom_range(9) == 0) ? sb.level_seen : !sb.level_seen;
         repeat (run) begin
            if (sb.status != STATUS_CAPT) break;
            if (noisy && $urandom_range(99) < 4) begin
               send_word(FUNC_W'($urandom_range(3)), 1'($urandom_range(1)));
            end else begin
               send_word(FUNC_SAMPLE, lvl);
               taken++;
            end
         end
      end
      case (sb.status)
         STATUS_DONE:    n_done++;
         STATUS_SHORT:   n_short++;
         STATUS_TIMEOUT: n_timeout++;
         default: ;
      endcase
      // Samples after the end must be ignored.
      if (noisy) repeat ($urandom_range(0, 2)) send_word(FUNC_SAMPLE, 1'($urandom_range(1)));
      reads = (sb.status == STATUS_DONE) ? sb.edge_cnt - 1 + $urandom_range(0, 2)
                                         : $urandom_range(0, 2);
      // Occasionally abandon the read-out part way and restart.
      if ($urandom_range(9) == 0) reads = $urandom_range(0, reads);
      repeat (reads) send_word(FUNC_READ, 1'($urandom_range(1)));
   endtask

   // Hard stop in case the block hangs.
   initial begin
      #5ms;
      $display("pulse_train_capture: mismatch");
      $finish;
   end

   initial begin
      int                    k;
      int                    random_start;
      int                    phase_start;
      logic [TIME_W-1:0]     iv;
      logic [TIME_W-1:0]     av;
      logic [CFG_EDGE_W-1:0] mn;
      logic [CFG_EDGE_W-1:0] mx;

      sb = new;
      sb.clear();
      gaps_on    = 1'b1;
      holdoff_go = 1'b0;
      words_sent = 0;
      n_done     = 0;
      n_short    = 0;
      n_timeout  = 0;

      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.func     = FUNC_START;
      req_chan.rx_level = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_IDLE_TIMEOUT;
      csr_wdata         = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: reads and samples while idle, the spare code, an edge at
      // tick zero, a read mid-capture and a start that restarts a live capture.
      send_word(FUNC_READ, 1'b0);
      send_word(FUNC_SAMPLE, 1'b1);
      send_word(FUNC_UNUSED, 1'b1);
      send_word(FUNC_START, 1'b0);
      send_word(FUNC_SAMPLE, 1'b1);
      send_word(FUNC_SAMPLE, 1'b0);
      send_word(FUNC_READ, 1'b1);
      send_word(FUNC_START, 1'b1);
      settle();

      // Abort limit of zero: the edge on the second tick still counts, then time out.
      program_regs('0, '0, '0, '0);
      send_word(FUNC_START, 1'b0);
      send_word(FUNC_SAMPLE, 1'b0);
      send_word(FUNC_SAMPLE, 1'b1);
      send_word(FUNC_READ, 1'b0);
      settle();

      // Idle limit of zero, minimum of one, edge limit above the store depth.
      program_regs('0, TIME_MAX, CFG_EDGE_W'(1), '1);
      send_word(FUNC_START, 1'b0);
      send_word(FUNC_SAMPLE, 1'b1);
      send_word(FUNC_SAMPLE, 1'b0);
      send_word(FUNC_SAMPLE, 1'b0);
      send_word(FUNC_READ, 1'b0);
      send_word(FUNC_READ, 1'b0);
      settle();

      // Largest idle limit, tiny abort limit: hold the level until the capture times out.
      program_regs(TIME_MAX, TIME_W'(5), CFG_EDGE_W'(2048), CFG_EDGE_W'(2));
      send_word(FUNC_START, 1'b0);
      repeat (7) send_word(FUNC_SAMPLE, 1'b1);
      send_word(FUNC_READ, 1'b1);
      settle();

      // Random phases, each under its own register setting.
      k = 0;
      random_start = words_sent;
      while (words_sent - random_start < RANDOM_WORDS) begin
         case (k % 8)
            0: begin
               iv = TIME_W'($urandom_range(2, 8));
               av = TIME_MAX;
               mn = CFG_EDGE_W'($urandom_range(2, 6));
               mx = CFG_EDGE_W'(2048);
            end
            1: begin
               iv = '0;
               av = TIME_MAX;
               mn = '0;
               mx = '1;
            end
            2: begin
               iv = TIME_MAX;
               av = TIME_MAX;
               mn = CFG_EDGE_W'(2048);
               mx = CFG_EDGE_W'(1);
            end
            3: begin
               iv = TIME_MAX;
               av = TIME_W'($urandom_range(1, 60));
               mn = CFG_EDGE_W'(2);
               mx = CFG_EDGE_W'(2048);
            end
            4: begin
               iv = TIME_W'($urandom_range(1, 6));
               av = TIME_W'($urandom_range(10, 80));
               mn = CFG_EDGE_W'($urandom_range(2, 8));
               mx = CFG_EDGE_W'($urandom_range(2, 12));
            end
            5: begin
               iv = TIME_W'(1);
               av = TIME_MAX;
               mn = CFG_EDGE_W'(1);
               mx = '0;
            end
            6: begin
               iv = TIME_W'($urandom_range(0, 10));
               av = TIME_W'($urandom_range(0, 100));
               mn = CFG_EDGE_W'($urandom_range(0, 12));
               mx = CFG_EDGE_W'($urandom_range(0, 16));
            end
            default: begin
               iv = TIME_W'($urandom_range(3, 12));
               av = TIME_W'($urandom_range(1000, 24'hFFFFFF));
               mn = '1;
               mx = CFG_EDGE_W'($urandom_range(2, 40));
            end
         endcase
         settle();
         // Every eighth phase, starting with the second, runs with no idling on either side.
         gaps_on = (k % 8 != 1);
         program_regs(iv, av, mn, mx);
         if (k == 3) holdoff_go = 1'b1;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            if ($urandom_range(4) == 0)
               repeat ($urandom_range(1, 3))
                  send_word(FUNC_W'($urandom_range(3)), 1'($urandom_range(1)));
            run_capture(120, $urandom_range(3) != 0);
         end
         k++;
      end
      gaps_on = 1'b1;
      settle();

      $display("run covered %0d request words over %0d register settings",
               words_sent, k + 4);
      $display("captures ended: %0d done, %0d too short, %0d timed out; %0d intervals read",
               n_done, n_short, n_timeout, sb.intervals_read);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("pulse_train_capture: match");
      end else begin
         $display("pulse_train_capture: mismatch");
      end
      $finish;
   end

endmodule
